/* hw/rtl/sstid_pkg.sv */
// ----------------------------------------------------------------------------
// sstid_pkg - shared types and constants for the session slot table
// Operation codes, register map, payload word types and default sizes.
// ----------------------------------------------------------------------------
package sstid_pkg;

  // default sizes
  localparam int SLOTS_DEF       = 16;
  localparam int MAX_PLAYERS_DEF = 8;

  // handshake window added to the allocate time
  localparam logic [31:0] HS_WINDOW = 32'd5000;

  // operation codes
  localparam logic [2:0] OP_ALLOC = 3'd0;
  localparam logic [2:0] OP_AUTH  = 3'd1;
  localparam logic [2:0] OP_REL   = 3'd2;
  localparam logic [2:0] OP_SEND  = 3'd3;
  localparam logic [2:0] OP_FIND  = 3'd4;
  localparam logic [2:0] OP_RST   = 3'd5;

  // register indexes and reset values
  localparam logic REG_HOST  = 1'b0;
  localparam logic REG_LIMIT = 1'b1;
  localparam logic [3:0] HOST_RST  = 4'd0;
  localparam logic [3:0] LIMIT_RST = 4'd8;

  // input word
  typedef struct packed {
    logic [2:0]  kind;
    logic [15:0] peer_tag;
    logic [31:0] now_time;
    logic        security_ok;
    logic [7:0]  wanted_player;
  } in_word_t;

  // result word
  typedef struct packed {
    logic        ok;
    logic [3:0]  slot_index;
    logic [3:0]  player_out;
    logic [31:0] deadline_out;
    logic [31:0] last_rx_out;
    logic [4:0]  auth_count;
    logic [4:0]  pending_count;
  } out_word_t;

endpackage

/* hw/rtl/session_slot_table_with_id_allocator.sv */
// ----------------------------------------------------------------------------
// session_slot_table_with_id_allocator - peer session table
// Slot table in one synchronous memory with lowest-free player id allocation.
// ----------------------------------------------------------------------------
// Usage:
//   in_*  : one operation word per handshake (allocate, authenticate, release,
//           sender lookup, find by player id, reset all).
//   out_* : exactly one result word per operation, in order.
//   cfg_* : APB-style register port, host id at 0x0, session limit at 0x4.
// Timing: an operation reads every slot once from the table memory (one read
//   per cycle, registered read data), then an authenticate walks the player
//   ids for the lowest free one. A word is taken only in idle, so the scan of
//   one word ends before the next word starts.
// The next word is taken while a result still waits in the output register;
//   a stalled receiver holds the commit of the following word only.
// Reset: slot valid bits and counters clear at once, so the table reads as
//   empty straight after reset; registers take host 0 and limit 8.
// ----------------------------------------------------------------------------
module session_slot_table_with_id_allocator #(
  parameter int SLOTS       = sstid_pkg::SLOTS_DEF,
  parameter int MAX_PLAYERS = sstid_pkg::MAX_PLAYERS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  sstid_pkg::in_word_t  in_data,
  output logic                 out_valid,
  input  logic                 out_ready,
  output sstid_pkg::out_word_t out_data,
  input  logic                 cfg_psel,
  input  logic                 cfg_penable,
  input  logic                 cfg_pwrite,
  input  logic [2:0]           cfg_paddr,
  input  logic [31:0]          cfg_pwdata,
  output logic [31:0]          cfg_prdata,
  output logic                 cfg_pready
);

  localparam int SW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CW  = $clog2(SLOTS + 1);
  localparam int PW  = $clog2(MAX_PLAYERS + 1);
  localparam int IW  = $clog2(MAX_PLAYERS);
  localparam logic [SW-1:0] LAST_SLOT = SW'(SLOTS - 1);
  localparam logic [IW-1:0] LAST_ID   = IW'(MAX_PLAYERS - 1);
  localparam logic [PW-1:0] NO_PLAYER = PW'(MAX_PLAYERS);

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_SCAN   = 5'b00010,
    ST_DECIDE = 5'b00100,
    ST_IDS    = 5'b01000,
    ST_COMMIT = 5'b10000
  } state_t;

  state_t state_r;

  // registers
  logic [3:0] host_r, limit_r;
  logic       cfg_wr;

  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg_prdata = (cfg_paddr[2] == sstid_pkg::REG_LIMIT) ? {28'd0, limit_r}
                                                             : {28'd0, host_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      host_r  <= sstid_pkg::HOST_RST;
      limit_r <= sstid_pkg::LIMIT_RST;
    end else if (cfg_wr) begin
      if (cfg_paddr[2] == sstid_pkg::REG_LIMIT) limit_r <= cfg_pwdata[3:0];
      else                                      host_r  <= cfg_pwdata[3:0];
    end
  end

  // slot table memory
  logic [15:0]    mem_peer [SLOTS];
  logic           mem_auth [SLOTS];
  logic [PW-1:0]  mem_player [SLOTS];
  logic [31:0]    mem_dl [SLOTS];
  logic [31:0]    mem_lrx [SLOTS];
  logic [SLOTS-1:0] vld_r;

  logic          rd_en, wr_en;
  logic [SW-1:0] rd_addr_r, wr_idx;
  logic [15:0]   rq_peer_r, wr_peer;
  logic          rq_auth_r, wr_auth;
  logic [PW-1:0] rq_player_r, wr_player;
  logic [31:0]   rq_dl_r, rq_lrx_r, wr_dl, wr_lrx;

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rq_peer_r   <= mem_peer[rd_addr_r];
      rq_auth_r   <= mem_auth[rd_addr_r];
      rq_player_r <= mem_player[rd_addr_r];
      rq_dl_r     <= mem_dl[rd_addr_r];
      rq_lrx_r    <= mem_lrx[rd_addr_r];
    end
    if (wr_en) begin
      mem_peer[wr_idx]   <= wr_peer;
      mem_auth[wr_idx]   <= wr_auth;
      mem_player[wr_idx] <= wr_player;
      mem_dl[wr_idx]     <= wr_dl;
      mem_lrx[wr_idx]    <= wr_lrx;
    end
  end

  // scan pipeline
  logic          iss_r, rd_pend_r;
  logic [SW-1:0] rd_idx_r;
  logic [15:0]   e_peer;
  logic          e_auth;
  logic [PW-1:0] e_player;
  logic [31:0]   e_dl, e_lrx;

  assign rd_en = (state_r == ST_SCAN) && iss_r;

  // unwritten slots read as empty
  always_comb begin
    e_peer   = rq_peer_r;
    e_auth   = rq_auth_r;
    e_player = rq_player_r;
    e_dl     = rq_dl_r;
    e_lrx    = rq_lrx_r;
    if (!vld_r[rd_idx_r]) begin
      e_peer   = '0;
      e_auth   = 1'b0;
      e_player = NO_PLAYER;
      e_dl     = '0;
      e_lrx    = '0;
    end
  end

  // latched word and scan results
  sstid_pkg::in_word_t item_r;
  logic          f_hit_r, f_auth_r, emp_hit_r, w_hit_r, id_ok_r;
  logic [SW-1:0] f_idx_r, emp_idx_r, w_idx_r;
  logic [PW-1:0] f_player_r, w_player_r;
  logic [31:0]   f_dl_r, f_lrx_r, w_dl_r, w_lrx_r;
  logic [MAX_PLAYERS-1:0] taken_r, taken_nxt;
  logic [IW-1:0] id_r;
  logic [CW-1:0] auth_r, pend_r, auth_nxt, pend_nxt;
  logic          room, peer_hit, want_hit, id_free, commit;
  sstid_pkg::out_word_t res;
  logic          clr_all;

  assign room = (limit_r >= 4'd2) && (32'(limit_r) <= MAX_PLAYERS) &&
                (32'(auth_r) + 32'd1 < 32'(limit_r));
  assign peer_hit = (item_r.peer_tag != 16'd0) && (e_peer == item_r.peer_tag);
  assign want_hit = e_auth && (8'(e_player) == item_r.wanted_player);
  assign id_free  = (32'(id_r) != 32'(host_r)) && !taken_r[id_r];
  assign commit   = (state_r == ST_COMMIT) && (!out_valid || out_ready);
  assign in_ready = (state_r == ST_IDLE);

  // ids held by authenticated slots
  always_comb begin
    taken_nxt = taken_r;
    for (int i = 0; i < MAX_PLAYERS; i++)
      if (e_auth && e_player == PW'(i)) taken_nxt[i] = 1'b1;
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      iss_r     <= 1'b0;
      rd_pend_r <= 1'b0;
    end else begin
      rd_pend_r <= rd_en;
      case (state_r)
        ST_IDLE: begin
          if (in_valid) begin
            state_r <= ST_SCAN;
            iss_r   <= 1'b1;
          end
        end
        ST_SCAN: begin
          if (rd_en && rd_addr_r == LAST_SLOT) iss_r <= 1'b0;
          if (rd_pend_r && rd_idx_r == LAST_SLOT) state_r <= ST_DECIDE;
        end
        ST_DECIDE: begin
          if (item_r.kind == sstid_pkg::OP_AUTH && f_hit_r && !f_auth_r &&
              item_r.security_ok && room)
            state_r <= ST_IDS;
          else
            state_r <= ST_COMMIT;
        end
        ST_IDS: begin
          if (id_free || id_r == LAST_ID) state_r <= ST_COMMIT;
        end
        ST_COMMIT: begin
          if (commit) state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // scan datapath
  always_ff @(posedge clk) begin
    if (state_r == ST_IDLE && in_valid) begin
      item_r    <= in_data;
      rd_addr_r <= '0;
      f_hit_r   <= 1'b0;
      emp_hit_r <= 1'b0;
      w_hit_r   <= 1'b0;
      id_ok_r   <= 1'b0;
      taken_r   <= '0;
      id_r      <= '0;
    end
    if (rd_en) begin
      rd_idx_r <= rd_addr_r;
      if (rd_addr_r != LAST_SLOT) rd_addr_r <= rd_addr_r + SW'(1);
    end
    if (state_r == ST_SCAN && rd_pend_r) begin
      taken_r <= taken_nxt;
      if (!f_hit_r && peer_hit) begin
        f_hit_r    <= 1'b1;
        f_idx_r    <= rd_idx_r;
        f_auth_r   <= e_auth;
        f_player_r <= e_player;
        f_dl_r     <= e_dl;
        f_lrx_r    <= e_lrx;
      end
      if (!emp_hit_r && e_peer == 16'd0) begin
        emp_hit_r <= 1'b1;
        emp_idx_r <= rd_idx_r;
      end
      if (!w_hit_r && want_hit) begin
        w_hit_r    <= 1'b1;
        w_idx_r    <= rd_idx_r;
        w_player_r <= e_player;
        w_dl_r     <= e_dl;
        w_lrx_r    <= e_lrx;
      end
    end
    // lowest free id walk
    if (state_r == ST_IDS) begin
      if (id_free) id_ok_r <= 1'b1;
      else if (id_r != LAST_ID) id_r <= id_r + IW'(1);
    end
  end

  // commit: result, table write, counters
  always_comb begin
    res           = '0;
    res.player_out = 4'(MAX_PLAYERS);
    wr_en     = 1'b0;
    wr_idx    = f_idx_r;
    wr_peer   = '0;
    wr_auth   = 1'b0;
    wr_player = NO_PLAYER;
    wr_dl     = '0;
    wr_lrx    = '0;
    auth_nxt  = auth_r;
    pend_nxt  = pend_r;
    clr_all   = 1'b0;
    case (item_r.kind)
      sstid_pkg::OP_ALLOC: begin
        if (item_r.peer_tag != 16'd0 && !f_hit_r && emp_hit_r) begin
          wr_en   = 1'b1;
          wr_idx  = emp_idx_r;
          wr_peer = item_r.peer_tag;
          wr_dl   = item_r.now_time + sstid_pkg::HS_WINDOW;
          pend_nxt = pend_r + CW'(1);
          res.ok           = 1'b1;
          res.slot_index   = 4'(emp_idx_r);
          res.deadline_out = wr_dl;
        end
      end
      sstid_pkg::OP_AUTH: begin
        if (id_ok_r) begin
          wr_en     = 1'b1;
          wr_peer   = item_r.peer_tag;
          wr_auth   = 1'b1;
          wr_player = PW'(id_r);
          wr_lrx    = item_r.now_time;
          auth_nxt  = auth_r + CW'(1);
          pend_nxt  = pend_r - CW'(1);
          res.ok          = 1'b1;
          res.slot_index  = 4'(f_idx_r);
          res.player_out  = 4'(id_r);
          res.last_rx_out = item_r.now_time;
        end
      end
      sstid_pkg::OP_REL: begin
        if (f_hit_r) begin
          wr_en = 1'b1;
          if (f_auth_r && auth_r != '0) auth_nxt = auth_r - CW'(1);
          if (!f_auth_r) pend_nxt = pend_r - CW'(1);
          res.ok         = 1'b1;
          res.slot_index = 4'(f_idx_r);
        end
      end
      sstid_pkg::OP_SEND: begin
        if (f_hit_r && f_auth_r) begin
          res.ok           = 1'b1;
          res.slot_index   = 4'(f_idx_r);
          res.player_out   = 4'(f_player_r);
          res.deadline_out = f_dl_r;
          res.last_rx_out  = f_lrx_r;
        end
      end
      sstid_pkg::OP_FIND: begin
        if (32'(item_r.wanted_player) < MAX_PLAYERS && w_hit_r) begin
          res.ok           = 1'b1;
          res.slot_index   = 4'(w_idx_r);
          res.player_out   = 4'(w_player_r);
          res.deadline_out = w_dl_r;
          res.last_rx_out  = w_lrx_r;
        end
      end
      sstid_pkg::OP_RST: begin
        clr_all  = 1'b1;
        auth_nxt = '0;
        pend_nxt = '0;
        res.ok   = 1'b1;
      end
      default: ;
    endcase
    wr_en = wr_en && commit;
    res.auth_count    = 5'(auth_nxt);
    res.pending_count = 5'(pend_nxt);
  end

  // counters, valid bits and output register
  sstid_pkg::out_word_t out_r;
  logic out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      auth_r      <= '0;
      pend_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (out_ready) out_valid_r <= 1'b0;
      if (commit) begin
        auth_r      <= auth_nxt;
        pend_r      <= pend_nxt;
        out_valid_r <= 1'b1;
        if (clr_all) vld_r <= '0;
        else if (wr_en) vld_r[wr_idx] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (commit) out_r <= res;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

  // checks
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(auth_r) + 32'(pend_r) <= SLOTS)
    else $error("session counters exceed slot count");

  a_accept_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == ST_SCAN))
    else $error("accepted word did not start a scan");

  a_rst_all: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && clr_all) |=> (auth_r == '0 && pend_r == '0 && vld_r == '0))
    else $error("reset all left state behind");

  a_commit_free: assert property (@(posedge clk) disable iff (!rst_n)
    commit |-> (!out_valid || out_ready))
    else $error("result overwritten before taken");

endmodule
